### rtl/two_grain_pitch_shifter_macros.svh
// assertion helpers used by the checker file
`ifndef TWO_GRAIN_PITCH_SHIFTER_MACROS_SVH
`define TWO_GRAIN_PITCH_SHIFTER_MACROS_SVH

// antecedent in this cycle implies consequent in the next, ignored during reset
`define TGPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// same form, but also checked while reset is applied
`define TGPS_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tgps_pkg.sv
package tgps_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int BUFFER_DEPTH   = 4096;  // power of two, write pointer wraps naturally
    localparam int ADDR_BITS      = $clog2(BUFFER_DEPTH);
    localparam int FILL_BITS      = ADDR_BITS + 1;
    localparam int MIN_READ_DELAY = 4;
    localparam int PHASE_BITS     = 24;
    localparam int GRAIN_BITS     = 12;
    localparam int INC_BITS       = 22;
    localparam int MIN_GRAIN      = 16;
    localparam int CFG_DATA_BITS  = 22;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [GRAIN_BITS-1:0] GRAIN_RESET = GRAIN_BITS'(2400);
    localparam logic [INC_BITS-1:0]   INC_RESET   = INC_BITS'(6991);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRAIN_LENGTH    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INCREMENT = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_BYPASS          = CFG_INDEX_BITS'(2);

    // delay = MIN_READ_DELAY + (1 - phase) * grain, integer part above PHASE_BITS
    localparam int DELAY_BITS = PHASE_BITS + 1 + GRAIN_BITS;
    localparam logic [DELAY_BITS-1:0] DELAY_OFFSET =
        DELAY_BITS'(MIN_READ_DELAY) << PHASE_BITS;

    // interpolation and weighted sum widths
    localparam int LERP_BITS     = 2 * SAMPLE_BITS + 2;
    localparam int WIN_BITS      = 18;
    localparam int WIN_FRAC_BITS = 17;
    localparam int WIN_ONE       = 1 << WIN_FRAC_BITS;
    localparam int ACC_BITS      = WIN_BITS + SAMPLE_BITS + 2;

    // quarter-wave window table
    localparam int WIN_TABLE_SIZE = 1024;
    localparam int WIN_SPAN       = 2 * WIN_TABLE_SIZE;
    localparam int WIN_ADDR_BITS  = $clog2(WIN_TABLE_SIZE + 1);
    localparam int WIN_IDX_BITS   = $clog2(WIN_SPAN + 1);

    typedef logic [WIN_BITS-1:0] win_table_t [0:WIN_TABLE_SIZE];

    // sin(pi/2 * k/N) in Q1.17 by a Q30 Taylor series
    function automatic win_table_t build_win_table();
        win_table_t          t;
        logic [63:0]         a;
        logic [63:0]         a2;
        logic [63:0]         term;
        logic signed [63:0]  sum;
        logic signed [63:0]  e;
        for (int k = 0; k <= WIN_TABLE_SIZE; k++) begin
            a    = (64'(k) * 64'd3373259426) / 64'(WIN_SPAN);
            a2   = (a * a) >> 30;
            term = a;
            sum  = signed'(a);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
            if (sum < 0)
                sum = 0;
            e = signed'((unsigned'(sum) * 64'(WIN_ONE) + (64'd1 << 29)) >> 30);
            if (e > WIN_ONE || k == WIN_TABLE_SIZE)
                e = 64'(WIN_ONE);
            t[k] = WIN_BITS'(e);
        end
        return t;
    endfunction

    localparam win_table_t WIN_TABLE = build_win_table();

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR_A,
        ST_ADDR_B,
        ST_RD_A1,
        ST_RD_B0,
        ST_LERP_A,
        ST_MAC_A,
        ST_LERP_B,
        ST_MAC_B,
        ST_OUT
    } tgps_state_t;

    typedef struct packed {
        logic accept;     // write the word, advance pointer and phase
        logic calc_en;    // compute tap address and fraction
        logic calc_b;
        logic rd_en;      // delay store read
        logic rd_b;
        logic rd_next;    // one sample further back
        logic cap_lo;
        logic cap_hi;
        logic lerp_en;
        logic lerp_b;
        logic win_en;
        logic win_cos;
        logic mac_en;
        logic mac_first;
        logic mac_b;
        logic out_load;
    } tgps_cmd_t;

endpackage

### rtl/two_grain_pitch_shifter.sv
// Two-grain pitch shifter for Q1.23 audio: every accepted word is written into a
// 4096-entry delay line, and the result is the sum of two linearly interpolated
// taps half a grain cycle apart, weighted by sin and |cos| of the grain phase and
// saturated. A shifted sample passes acceptance, two address calculations, four
// delay-line reads through the single read port, two interpolations, two window
// multiplies and the result-register load; bypass goes from acceptance to the load.
// A new word is taken as soon as the previous one has reached the output register,
// even if that result is still waiting. Delay-line entries never written since
// reset read as zero, tracked by a fill count, so no clearing pass is needed
// after reset. The user writes the configuration registers only while no word is
// in flight, through cfg_wr_en/cfg_index/cfg_data; the block does not enforce it.
module two_grain_pitch_shifter (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [tgps_pkg::SAMPLE_BITS-1:0] s_sample_in,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [tgps_pkg::SAMPLE_BITS-1:0] m_sample_out,
    input  logic                                    cfg_wr_en,
    input  logic [tgps_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [tgps_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    import tgps_pkg::*;

    tgps_cmd_t cmd;
    logic      bypass;

    tgps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .bypass  (bypass),
        .cmd     (cmd)
    );

    tgps_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_sample_in  (s_sample_in),
        .bypass       (bypass),
        .m_sample_out (m_sample_out)
    );

endmodule

### rtl/tgps_ram.sv
module tgps_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/tgps_ctrl.sv
module tgps_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  logic                bypass,
    output tgps_pkg::tgps_cmd_t cmd
);

    import tgps_pkg::*;

    tgps_state_t state_reg;
    tgps_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = bypass ? ST_OUT : ST_ADDR_A;
                end
            end
            ST_ADDR_A: begin
                cmd.calc_en = 1'b1;
                state_next  = ST_ADDR_B;
            end
            ST_ADDR_B: begin
                cmd.calc_en = 1'b1;
                cmd.calc_b  = 1'b1;
                cmd.rd_en   = 1'b1;
                state_next  = ST_RD_A1;
            end
            ST_RD_A1: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_next = 1'b1;
                cmd.cap_lo  = 1'b1;
                state_next  = ST_RD_B0;
            end
            ST_RD_B0: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_b   = 1'b1;
                cmd.cap_hi = 1'b1;
                state_next = ST_LERP_A;
            end
            ST_LERP_A: begin
                // grain a interpolates while grain b samples stream in
                cmd.lerp_en = 1'b1;
                cmd.cap_lo  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_b    = 1'b1;
                cmd.rd_next = 1'b1;
                cmd.win_en  = 1'b1;
                state_next  = ST_MAC_A;
            end
            ST_MAC_A: begin
                cmd.cap_hi    = 1'b1;
                cmd.mac_en    = 1'b1;
                cmd.mac_first = 1'b1;
                cmd.win_en    = 1'b1;
                cmd.win_cos   = 1'b1;
                state_next    = ST_LERP_B;
            end
            ST_LERP_B: begin
                cmd.lerp_en = 1'b1;
                cmd.lerp_b  = 1'b1;
                state_next  = ST_MAC_B;
            end
            ST_MAC_B: begin
                cmd.mac_en = 1'b1;
                cmd.mac_b  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### rtl/tgps_datapath.sv
module tgps_datapath (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  tgps_pkg::tgps_cmd_t                       cmd,
    input  logic                                      cfg_wr_en,
    input  logic [tgps_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [tgps_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  logic signed [tgps_pkg::SAMPLE_BITS-1:0]   s_sample_in,
    output logic                                      bypass,
    output logic signed [tgps_pkg::SAMPLE_BITS-1:0]   m_sample_out
);

    import tgps_pkg::*;

    // configuration
    logic [GRAIN_BITS-1:0] grain_length_reg;
    logic [INC_BITS-1:0]   phase_increment_reg;
    logic                  bypass_reg;

    // stream state
    logic [ADDR_BITS-1:0]  wp_reg;
    logic [FILL_BITS-1:0]  fill_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    // per-item working registers
    logic [ADDR_BITS-1:0]  addr_a_reg;
    logic [ADDR_BITS-1:0]  addr_b_reg;
    logic [PHASE_BITS-1:0] frac_a_reg;
    logic [PHASE_BITS-1:0] frac_b_reg;
    logic                  rd_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s_lo_reg;
    logic signed [SAMPLE_BITS-1:0] s_hi_reg;
    logic signed [SAMPLE_BITS-1:0] tap_a_reg;
    logic signed [SAMPLE_BITS-1:0] tap_b_reg;
    logic [WIN_BITS-1:0]           win_q_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    logic [PHASE_BITS-1:0]  calc_phase;
    logic [PHASE_BITS:0]    one_minus;
    logic [GRAIN_BITS-1:0]  grain_eff;
    logic [DELAY_BITS-1:0]  delay_prod;
    logic [DELAY_BITS-1:0]  delay;
    logic [ADDR_BITS-1:0]   tap_addr;

    logic [ADDR_BITS-1:0]   rd_base;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic signed [SAMPLE_BITS-1:0] rd_sample;

    logic [PHASE_BITS-1:0]        lerp_frac;
    logic signed [SAMPLE_BITS:0]  lerp_diff;
    logic signed [LERP_BITS-1:0]  lerp_prod;
    logic signed [LERP_BITS-1:0]  lerp_sum;
    logic signed [SAMPLE_BITS-1:0] tap_next;

    logic [PHASE_BITS+WIN_IDX_BITS-1:0] j_full;
    logic [WIN_IDX_BITS-1:0]  win_j;
    logic [WIN_ADDR_BITS-1:0] sin_idx;
    logic [WIN_ADDR_BITS-1:0] cos_idx;
    logic [WIN_ADDR_BITS-1:0] win_addr;

    logic signed [SAMPLE_BITS-1:0] mac_tap;
    logic signed [ACC_BITS-1:0]    mac_prod;
    logic signed [ACC_BITS-1:0]    acc_next;
    logic signed [ACC_BITS-1:0]    acc_round;
    logic signed [ACC_BITS-1:0]    y_full;
    logic [ACC_BITS-SAMPLE_BITS:0] y_top;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grain_length_reg    <= GRAIN_RESET;
            phase_increment_reg <= INC_RESET;
            bypass_reg          <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GRAIN_LENGTH:    grain_length_reg    <= cfg_data[GRAIN_BITS-1:0];
                REG_PHASE_INCREMENT: phase_increment_reg <= cfg_data[INC_BITS-1:0];
                REG_BYPASS:          bypass_reg          <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            fill_reg  <= '0;
            phase_reg <= '0;
        end else if (cmd.accept) begin
            wp_reg <= wp_reg + 1'b1;
            // entries at or above the fill count have not been written since reset
            if (fill_reg != FILL_BITS'(BUFFER_DEPTH)) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (!bypass_reg) begin
                phase_reg <= phase_reg + PHASE_BITS'(phase_increment_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= s_sample_in;
        end
    end

    // tap address: write pointer minus integer delay
    assign calc_phase = cmd.calc_b ? (phase_reg ^ (PHASE_BITS'(1) << (PHASE_BITS - 1)))
                                   : phase_reg;
    assign one_minus  = ((PHASE_BITS + 1)'(1) << PHASE_BITS) - {1'b0, calc_phase};
    assign grain_eff  = (grain_length_reg < GRAIN_BITS'(MIN_GRAIN)) ? GRAIN_BITS'(MIN_GRAIN)
                                                                   : grain_length_reg;
    assign delay_prod = DELAY_BITS'(one_minus) * DELAY_BITS'(grain_eff);
    assign delay      = delay_prod + DELAY_OFFSET;
    assign tap_addr   = wp_reg - ADDR_BITS'(delay >> PHASE_BITS);

    always_ff @(posedge aclk) begin
        if (cmd.calc_en) begin
            if (cmd.calc_b) begin
                addr_b_reg <= tap_addr;
                frac_b_reg <= delay[PHASE_BITS-1:0];
            end else begin
                addr_a_reg <= tap_addr;
                frac_a_reg <= delay[PHASE_BITS-1:0];
            end
        end
    end

    // delay store
    assign rd_base = cmd.rd_b ? addr_b_reg : addr_a_reg;
    assign rd_addr = rd_base - ADDR_BITS'(cmd.rd_next);

    tgps_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_delay_ram (
        .aclk    (aclk),
        .wr_en   (cmd.accept),
        .wr_addr (wp_reg),
        .wr_data (s_sample_in),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_valid_reg <= ({1'b0, rd_addr} < fill_reg);
        end
    end

    assign rd_sample = rd_valid_reg ? signed'(ram_rdata) : '0;

    always_ff @(posedge aclk) begin
        if (cmd.cap_lo) begin
            s_lo_reg <= rd_sample;
        end
        if (cmd.cap_hi) begin
            s_hi_reg <= rd_sample;
        end
    end

    // linear interpolation: lo + (hi - lo) * frac, rounded, floor shift
    assign lerp_frac = cmd.lerp_b ? frac_b_reg : frac_a_reg;
    assign lerp_diff = (SAMPLE_BITS + 1)'(s_hi_reg) - (SAMPLE_BITS + 1)'(s_lo_reg);
    assign lerp_prod = LERP_BITS'(lerp_diff) * LERP_BITS'(signed'({1'b0, lerp_frac}));
    assign lerp_sum  = (LERP_BITS'(s_lo_reg) <<< PHASE_BITS) + lerp_prod
                     + (LERP_BITS'(1) << (PHASE_BITS - 1));
    assign tap_next  = SAMPLE_BITS'(lerp_sum >>> PHASE_BITS);

    always_ff @(posedge aclk) begin
        if (cmd.lerp_en) begin
            if (cmd.lerp_b)
                tap_b_reg <= tap_next;
            else
                tap_a_reg <= tap_next;
        end
    end

    // window index j in 0..2N, folded onto the quarter wave
    assign j_full   = {{WIN_IDX_BITS{1'b0}}, phase_reg} * (PHASE_BITS + WIN_IDX_BITS)'(WIN_SPAN)
                    + ((PHASE_BITS + WIN_IDX_BITS)'(1) << (PHASE_BITS - 1));
    assign win_j    = WIN_IDX_BITS'(j_full >> PHASE_BITS);
    assign sin_idx  = (win_j <= WIN_IDX_BITS'(WIN_TABLE_SIZE))
                    ? WIN_ADDR_BITS'(win_j)
                    : WIN_ADDR_BITS'(WIN_IDX_BITS'(WIN_SPAN) - win_j);
    assign cos_idx  = (win_j <= WIN_IDX_BITS'(WIN_TABLE_SIZE))
                    ? WIN_ADDR_BITS'(WIN_IDX_BITS'(WIN_TABLE_SIZE) - win_j)
                    : WIN_ADDR_BITS'(win_j - WIN_IDX_BITS'(WIN_TABLE_SIZE));
    assign win_addr = cmd.win_cos ? cos_idx : sin_idx;

    always_ff @(posedge aclk) begin
        if (cmd.win_en) begin
            win_q_reg <= WIN_TABLE[win_addr];
        end
    end

    // weighted sum of the two grains
    assign mac_tap  = cmd.mac_b ? tap_b_reg : tap_a_reg;
    assign mac_prod = ACC_BITS'(signed'({1'b0, win_q_reg})) * ACC_BITS'(mac_tap);
    assign acc_next = cmd.mac_first ? mac_prod : (acc_reg + mac_prod);

    always_ff @(posedge aclk) begin
        if (cmd.mac_en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_round = acc_reg + (ACC_BITS'(1) << (WIN_FRAC_BITS - 1));
    assign y_full    = acc_round >>> WIN_FRAC_BITS;
    assign y_top     = y_full[ACC_BITS-1:SAMPLE_BITS-1];

    always_comb begin
        if ((&y_top) || !(|y_top))
            y_sat = y_full[SAMPLE_BITS-1:0];
        else if (y_full[ACC_BITS-1])
            y_sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        else
            y_sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= bypass_reg ? sample_reg : y_sat;
        end
    end

    assign bypass       = bypass_reg;
    assign m_sample_out = out_reg;

endmodule

### rtl/tgps_checker.sv
`include "two_grain_pitch_shifter_macros.svh"

module tgps_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [tgps_pkg::SAMPLE_BITS-1:0]  m_sample_out
);

    // one word at a time: the block is busy right after taking a word
    `TGPS_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "word taken back to back")

    `TGPS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_sample_out), "stalled result changed")

    // after reset the result side is empty and the input side open
    `TGPS_ASSERT_RESET(a_reset_state, !aresetn, !m_valid && s_ready, "bad state after reset")

endmodule

bind two_grain_pitch_shifter tgps_checker u_tgps_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out)
);

### dv/two_grain_pitch_shifter_tb.sv
`timescale 1ns / 1ps

module two_grain_pitch_shifter_tb;

    import tgps_pkg::*;

    localparam int    RANDOM_WORDS   = 1200;
    localparam int    DRAIN_CYCLES   = 14;
    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    MAX_REPORTS    = 30;
    localparam longint SAMPLE_MAX    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN    = -SAMPLE_MAX - 1;

    // index with no register behind it
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = CFG_INDEX_BITS'(3);

    typedef enum {SIG_NOISE, SIG_SQUARE, SIG_EDGES} sig_style_t;
    typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_STALLS} rx_mode_t;

    class pitch_scoreboard;
        logic signed [SAMPLE_BITS-1:0] history [BUFFER_DEPTH];
        logic [ADDR_BITS-1:0]          wr_ptr;
        logic [PHASE_BITS-1:0]         phase;
        logic [GRAIN_BITS-1:0]         grain;
        logic [INC_BITS-1:0]           step;
        logic                          bypass;
        longint                        window [0:WIN_TABLE_SIZE];
        logic signed [SAMPLE_BITS-1:0] due_samples [$];
        int                            mismatches;

        function new();
            longint unsigned a, a2, term, mag;
            longint          sum;
            foreach (history[i]) history[i] = '0;
            wr_ptr     = '0;
            phase      = '0;
            grain      = GRAIN_RESET;
            step       = INC_RESET;
            bypass     = 1'b0;
            mismatches = 0;
            // quarter sine in Q1.17 from a Q30 Taylor series, same rounding as the table
            for (int k = 0; k <= WIN_TABLE_SIZE; k++) begin
                a    = (64'(k) * 64'd3373259426) / WIN_SPAN;
                a2   = (a * a) >> 30;
                term = a;
                sum  = a;
                for (int n = 1; n <= 10; n++) begin
                    term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
                    sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
                end
                if (sum < 0)
                    sum = 0;
                mag = sum;
                window[k] = longint'((mag * WIN_ONE + (64'd1 << 29)) >> 30);
                if (window[k] > WIN_ONE || k == WIN_TABLE_SIZE)
                    window[k] = longint'(WIN_ONE);
            end
        endfunction

        function int pending();
            return due_samples.size();
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_GRAIN_LENGTH:    grain  = data[GRAIN_BITS-1:0];
                REG_PHASE_INCREMENT: step   = data[INC_BITS-1:0];
                REG_BYPASS:          bypass = data[0];
                default: ;
            endcase
        endfunction

        // sample written back_steps words ago, 1 being the newest
        function longint stored(longint unsigned back_steps);
            logic [ADDR_BITS-1:0] idx;
            longint               v;
            idx = wr_ptr - ADDR_BITS'(back_steps);
            v   = longint'(history[idx]);
            return v;
        endfunction

        function longint interp_tap(logic [PHASE_BITS-1:0] ph, logic [GRAIN_BITS-1:0] g);
            longint unsigned span, whole;
            longint          frac, acc;
            span  = (64'(MIN_READ_DELAY) << PHASE_BITS) + ((64'd1 << PHASE_BITS) - ph) * g;
            whole = span >> PHASE_BITS;
            frac  = span & ((64'd1 << PHASE_BITS) - 1);
            acc   = stored(whole) * ((longint'(1) <<< PHASE_BITS) - frac)
                  + stored(whole + 1) * frac;
            return (acc + (longint'(1) <<< (PHASE_BITS - 1))) >>> PHASE_BITS;
        endfunction

        function void take_sample(logic signed [SAMPLE_BITS-1:0] x);
            logic [PHASE_BITS-1:0] half_phase;
            logic [GRAIN_BITS-1:0] g;
            int unsigned           j;
            longint                w_sin, w_cos, y;
            history[wr_ptr] = x;
            wr_ptr = wr_ptr + 1'b1;
            if (bypass) begin
                due_samples.push_back(x);
                return;
            end
            phase      = phase + step;
            half_phase = phase ^ (PHASE_BITS'(1) << (PHASE_BITS - 1));
            g          = (grain < MIN_GRAIN) ? GRAIN_BITS'(MIN_GRAIN) : grain;
            j = int'((64'(phase) * WIN_SPAN + (64'd1 << (PHASE_BITS - 1))) >> PHASE_BITS);
            // second half of the cycle mirrors the quarter table
            if (j <= WIN_TABLE_SIZE) begin
                w_sin = window[j];
                w_cos = window[WIN_TABLE_SIZE - j];
            end else begin
                w_sin = window[WIN_SPAN - j];
                w_cos = window[j - WIN_TABLE_SIZE];
            end
            y = w_sin * interp_tap(phase, g) + w_cos * interp_tap(half_phase, g);
            y = (y + (longint'(1) <<< (WIN_FRAC_BITS - 1))) >>> WIN_FRAC_BITS;
            if (y > SAMPLE_MAX)
                y = SAMPLE_MAX;
            if (y < SAMPLE_MIN)
                y = SAMPLE_MIN;
            due_samples.push_back(SAMPLE_BITS'(y));
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_REPORTS)
                $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_sample(logic signed [SAMPLE_BITS-1:0] got);
            logic signed [SAMPLE_BITS-1:0] want;
            if (due_samples.size() == 0) begin
                report_mismatch($sformatf("sample_out %0d with no word pending", got));
                return;
            end
            want = due_samples.pop_front();
            if (got !== want)
                report_mismatch($sformatf("sample_out got %0d want %0d", got, want));
        endtask
    endclass

    logic                             aclk;
    logic                             aresetn      = 1'b0;
    logic                             s_valid      = 1'b0;
    logic                             s_ready;
    logic signed [SAMPLE_BITS-1:0]    s_sample_in  = '0;
    logic                             m_valid;
    logic                             m_ready      = 1'b0;
    logic signed [SAMPLE_BITS-1:0]    m_sample_out;
    logic                             cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]        cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]         cfg_data     = '0;

    logic signed [SAMPLE_BITS-1:0] corners [7] = '{24'sh7FFFFF, 24'sh800000, 24'sh000000,
                                                   24'shFFFFFF, 24'sh000001, 24'sh555555,
                                                   24'shAAAAAA};

    pitch_scoreboard sb;
    int              quiet_cycles = 0;

    two_grain_pitch_shifter u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                sb.set_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.take_sample(s_sample_in);
            if (m_valid && m_ready)
                sb.check_sample(m_sample_out);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : receiver
        rx_mode_t mode;
        int       span;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    RX_STREAM: m_ready = 1'b1;
                    RX_COIN:   m_ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready = ($urandom_range(0, 3) == 0);
                    default:   m_ready = ($urandom_range(0, 19) == 0);
                endcase
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] word);
        s_sample_in = word;
        s_valid     = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // let every pending word come out before touching registers
    task automatic settle();
        s_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin : stimulus
        int                            left, chunk, burst, gap;
        bit                            steady, level;
        sig_style_t                    style;
        logic [GRAIN_BITS-1:0]         g;
        logic [INC_BITS-1:0]           inc;
        logic signed [SAMPLE_BITS-1:0] x;
        sb    = new();
        level = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset configuration
        foreach (corners[i])
            send_sample(corners[i]);
        settle();

        // bypass, with the unused upper bits set
        set_reg(REG_BYPASS, 22'h3FFFFF);
        for (int i = 0; i < 3; i++)
            send_sample(corners[i]);
        settle();

        // bypass off, grain below minimum after masking, increment wraps fast
        set_reg(REG_BYPASS, 22'h2AAAAA);
        set_reg(REG_GRAIN_LENGTH, 22'h3FF00F);
        set_reg(REG_PHASE_INCREMENT, 22'h3FFFFF);
        set_reg(REG_SPARE, 22'h3FFFFF);
        for (int i = 0; i < 5; i++)
            send_sample(corners[i]);
        settle();

        set_reg(REG_GRAIN_LENGTH, '0);
        set_reg(REG_PHASE_INCREMENT, '0);
        for (int i = 3; i < 6; i++)
            send_sample(corners[i]);
        settle();

        // longest grain reads past the end of the store
        set_reg(REG_GRAIN_LENGTH, 22'hFFF);
        set_reg(REG_PHASE_INCREMENT, 22'h200000);
        for (int i = 0; i < 4; i++)
            send_sample(corners[6 - i]);

        left = RANDOM_WORDS;
        while (left > 0) begin
            settle();
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0:       g = GRAIN_BITS'(MIN_GRAIN);
                    1:       g = GRAIN_BITS'(4000);
                    2:       g = '1;
                    3:       g = GRAIN_BITS'($urandom_range(0, MIN_GRAIN - 1));
                    4:       g = GRAIN_BITS'($urandom_range(MIN_GRAIN, 300));
                    default: g = GRAIN_BITS'($urandom_range(MIN_GRAIN, 4095));
                endcase
                set_reg(REG_GRAIN_LENGTH, {10'($urandom), g});
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0:       inc = '0;
                    1:       inc = 22'h200000;
                    2:       inc = '1;
                    3:       inc = INC_BITS'($urandom_range(1, 20000));
                    4:       inc = INC_RESET;
                    default: inc = INC_BITS'($urandom);
                endcase
                set_reg(REG_PHASE_INCREMENT, inc);
            end
            if ($urandom_range(0, 1) == 0)
                set_reg(REG_BYPASS, {21'($urandom), 1'($urandom_range(0, 5) == 0)});
            if ($urandom_range(0, 7) == 0)
                set_reg(REG_SPARE, 22'($urandom));

            chunk = $urandom_range(40, 200);
            if (chunk > left)
                chunk = left;
            left  -= chunk;
            style  = sig_style_t'($urandom_range(0, 2));
            steady = ($urandom_range(0, 4) == 0);
            while (chunk > 0) begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && chunk > 0) begin
                    case (style)
                        // long runs at full scale drive the sum into saturation
                        SIG_SQUARE: begin
                            if ($urandom_range(0, 99) == 0)
                                level = ~level;
                            x = level ? 24'sh7FFFFF : 24'sh800000;
                        end
                        SIG_EDGES: begin
                            case ($urandom_range(0, 4))
                                0:       x = 24'sh7FFFFF;
                                1:       x = 24'sh800000;
                                2:       x = SAMPLE_BITS'(int'($urandom_range(0, 3)) - 2);
                                default: x = SAMPLE_BITS'($urandom);
                            endcase
                        end
                        default: x = SAMPLE_BITS'($urandom);
                    endcase
                    send_sample(x);
                    burst--;
                    chunk--;
                end
                gap = steady ? 0 : $urandom_range(0, 12);
                if (gap > 0) begin
                    s_valid = 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            s_valid = 1'b0;
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/tgps_pkg.sv
rtl/tgps_ram.sv
rtl/tgps_ctrl.sv
rtl/tgps_datapath.sv
rtl/two_grain_pitch_shifter.sv
rtl/tgps_checker.sv
dv/two_grain_pitch_shifter_tb.sv
